[src/hpet_pkg.sv]
package hpet_pkg;

   localparam int OPC_W      = 2;
   localparam int OFF_W      = 10;
   localparam int DATA_W     = 64;
   localparam int HALF_W     = 32;
   localparam int TIMER_IDX_W = 5;
   localparam int PERIOD_W   = 27;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam int CTL_W      = 4;

   localparam int MAX_MSGS   = 4;
   localparam int SENT_W     = $clog2(MAX_MSGS);

   typedef enum logic [OPC_W-1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_TICK  = 2'd2,
      OP_NONE  = 2'd3
   } hpet_op_type;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDE   = 1'd1;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 27'd69841279;

   // register map
   localparam logic [OFF_W-1:0] OFF_CAP   = 10'h000;
   localparam logic [OFF_W-1:0] OFF_GCFG  = 10'h010;
   localparam logic [OFF_W-1:0] OFF_STS   = 10'h020;
   localparam logic [OFF_W-1:0] OFF_CNT   = 10'h0f0;
   localparam logic [TIMER_IDX_W-1:0] TIMER_BLOCK_BASE = 5'd8;  // 0x100 >> 5
   localparam logic [4:0] SUB_CFG   = 5'h00;
   localparam logic [4:0] SUB_CMP   = 5'h08;
   localparam logic [4:0] SUB_ROUTE = 5'h10;

   localparam logic [7:0] CAP_REVISION = 8'h01;
   localparam int CAP_WIDE_BIT = 13;

   // stored comparator control bits
   localparam int CTL_LEVEL  = 0;
   localparam int CTL_ENABLE = 1;
   localparam int CTL_MODE32 = 2;
   localparam int CTL_FSB    = 3;

   // comparator configuration word bits
   localparam int WB_LEVEL   = 1;
   localparam int WB_ENABLE  = 2;
   localparam int WB_CAP64   = 5;
   localparam int WB_MODE32  = 8;
   localparam int WB_FSB     = 14;
   localparam int WB_FSB_CAP = 15;

   typedef struct packed {
      logic cfg_we;
      logic cmp_we;
      logic route_we;
   } hpet_cell_wr_type;

   typedef struct packed {
      logic hit;
      logic fsb;
   } hpet_cell_sts_type;

endpackage

[src/hpet_ifs.sv]
interface hpet_req_if;
   import hpet_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [OPC_W-1:0]     opcode;
   logic [OFF_W-1:0]     reg_offset;
   logic [DATA_W-1:0]    write_value;
   modport source (output valid, output opcode, output reg_offset, output write_value,
                   input ready);
   modport sink   (input valid, input opcode, input reg_offset, input write_value,
                   output ready);
endinterface

interface hpet_rsp_if;
   import hpet_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [DATA_W-1:0]      read_value;
   logic                   is_message;
   logic [HALF_W-1:0]      message_address;
   logic [HALF_W-1:0]      message_data;
   logic [TIMER_IDX_W-1:0] firing_timer;
   logic                   last_result;
   modport source (output valid, output read_value, output is_message,
                   output message_address, output message_data, output firing_timer,
                   output last_result, input ready);
   modport sink   (input valid, input read_value, input is_message,
                   input message_address, input message_data, input firing_timer,
                   input last_result, output ready);
endinterface

interface hpet_csr_if;
   import hpet_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[src/hpet_cell.sv]
module hpet_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wide,
   input  hpet_pkg::hpet_cell_wr_type wr,
   input  logic [63:0]               wdata,
   input  logic [63:0]               cnt_next,
   output hpet_pkg::hpet_cell_sts_type sts,
   output logic [63:0]               cfg_word,
   output logic [63:0]               cmp_value,
   output logic [63:0]               route
);
   import hpet_pkg::*;

   logic [CTL_W-1:0]  ctl_ff, ctl_in;
   logic [DATA_W-1:0] cmp_ff, cmp_in;
   logic [DATA_W-1:0] route_ff, route_in;
   logic              narrow;
   logic              match;

   assign narrow = !wide || ctl_ff[CTL_MODE32];

   always_comb begin
      ctl_in   = ctl_ff;
      cmp_in   = cmp_ff;
      route_in = route_ff;
      if (wr.cfg_we) begin
         ctl_in[CTL_LEVEL]  = wdata[WB_LEVEL];
         ctl_in[CTL_ENABLE] = wdata[WB_ENABLE];
         ctl_in[CTL_MODE32] = wdata[WB_MODE32];
         ctl_in[CTL_FSB]    = wdata[WB_FSB];
      end
      if (wr.cmp_we) begin
         cmp_in = narrow ? {{HALF_W{1'b0}}, wdata[HALF_W-1:0]} : wdata;
      end
      if (wr.route_we) begin
         route_in = wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff   <= '0;
         cmp_ff   <= '1;
         route_ff <= '0;
      end else begin
         ctl_ff   <= ctl_in;
         cmp_ff   <= cmp_in;
         route_ff <= route_in;
      end
   end

   assign match = narrow ? (cnt_next[HALF_W-1:0] == cmp_ff[HALF_W-1:0])
                         : (cnt_next == cmp_ff);

   assign sts.hit = ctl_ff[CTL_ENABLE] && match;
   assign sts.fsb = ctl_ff[CTL_FSB];

   always_comb begin
      cfg_word             = '0;
      cfg_word[WB_FSB_CAP] = 1'b1;
      cfg_word[WB_LEVEL]   = ctl_ff[CTL_LEVEL];
      cfg_word[WB_ENABLE]  = ctl_ff[CTL_ENABLE];
      cfg_word[WB_CAP64]   = wide;
      cfg_word[WB_MODE32]  = ctl_ff[CTL_MODE32];
      cfg_word[WB_FSB]     = ctl_ff[CTL_FSB];
   end

   assign cmp_value = cmp_ff;
   assign route     = route_ff;

endmodule

[src/hpet_out_buf.sv]
module hpet_out_buf #(
   parameter int NUM_TIMERS = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  logic                         load_read,
   input  logic [63:0]                  load_value,
   input  logic [NUM_TIMERS-1:0]        load_mask,
   input  logic [NUM_TIMERS-1:0][63:0]  routes,
   output logic                         free,
   hpet_rsp_if.source                   rsp
);
   import hpet_pkg::*;

   logic                  rd_pend_ff, rd_pend_in;
   logic [DATA_W-1:0]     rd_val_ff, rd_val_in;
   logic [NUM_TIMERS-1:0] msk_ff, msk_in;
   logic [SENT_W-1:0]     sent_ff, sent_in;

   logic [NUM_TIMERS-1:0]  low_hot;
   logic [NUM_TIMERS-1:0]  msk_rest;
   logic [TIMER_IDX_W-1:0] low_idx;
   logic [DATA_W-1:0]      low_route;
   logic                   msg_active;
   logic                   last_msg;
   logic                   xfer;

   // lowest pending comparator goes out first
   assign low_hot    = msk_ff & (~msk_ff + 1'b1);
   assign msk_rest   = msk_ff & ~low_hot;
   assign msg_active = |msk_ff;
   assign last_msg   = (msk_rest == '0) || (sent_ff == SENT_W'(MAX_MSGS - 1));

   always_comb begin
      low_idx   = '0;
      low_route = '0;
      for (int n = 0; n < NUM_TIMERS; n++) begin
         if (low_hot[n]) begin
            low_idx   = low_idx | TIMER_IDX_W'(n);
            low_route = low_route | routes[n];
         end
      end
   end

   assign rsp.valid = rd_pend_ff || msg_active;
   assign xfer      = rsp.valid && rsp.ready;
   assign free      = !rsp.valid || (xfer && (rd_pend_ff || last_msg));

   always_comb begin
      if (rd_pend_ff) begin
         rsp.read_value      = rd_val_ff;
         rsp.is_message      = 1'b0;
         rsp.message_address = '0;
         rsp.message_data    = '0;
         rsp.firing_timer    = '0;
         rsp.last_result     = 1'b1;
      end else begin
         rsp.read_value      = '0;
         rsp.is_message      = 1'b1;
         rsp.message_address = low_route[DATA_W-1:HALF_W];
         rsp.message_data    = low_route[HALF_W-1:0];
         rsp.firing_timer    = low_idx;
         rsp.last_result     = last_msg;
      end
   end

   always_comb begin
      rd_pend_in = rd_pend_ff;
      rd_val_in  = rd_val_ff;
      msk_in     = msk_ff;
      sent_in    = sent_ff;
      if (load) begin
         rd_pend_in = load_read;
         rd_val_in  = load_value;
         msk_in     = load_mask;
         sent_in    = '0;
      end else if (xfer) begin
         if (rd_pend_ff) begin
            rd_pend_in = 1'b0;
         end else if (last_msg) begin
            msk_in = '0;
         end else begin
            msk_in  = msk_rest;
            sent_in = sent_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
         msk_ff     <= '0;
         sent_ff    <= '0;
      end else begin
         rd_pend_ff <= rd_pend_in;
         msk_ff     <= msk_in;
         sent_ff    <= sent_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_val_ff <= rd_val_in;
   end

endmodule

[src/hpet_event_timer.sv]
// Channel | Dir | Transfer carries
// req     | in  | opcode, reg_offset, write_value
// rsp     | out | read_value, is_message, message_address, message_data,
//         |     | firing_timer, last_result
// csr     | in  | index, data (period, counter width)
//
// One item per clock while the output buffer is free: an accepted item sits
// in the input register, executes against the register file, and its results
// are registered in the output buffer. A tick firing k message comparators
// holds the buffer until its k messages are out (k at most 4); the next item
// waits there. Synchronous reset clears the control and state registers,
// not data registers. Back-pressure on rsp stalls execution and then req.
module hpet_event_timer #(
   parameter int NUM_TIMERS = 4
) (
   input  logic       clock,
   input  logic       reset,
   hpet_req_if.sink   req,
   hpet_rsp_if.source rsp,
   hpet_csr_if.sink   csr
);
   import hpet_pkg::*;

   logic [PERIOD_W-1:0] period_ff;
   logic                wide_ff;

   logic              in_vld_ff, in_vld_in;
   hpet_op_type       in_op_ff;
   logic [OFF_W-1:0]  in_off_ff;
   logic [DATA_W-1:0] in_val_ff;

   logic                  gen_en_ff, gen_en_in;
   logic [DATA_W-1:0]     cnt_ff, cnt_in;
   logic [NUM_TIMERS-1:0] sts_ff, sts_in;

   logic                   buf_free;
   logic                   exec_go;
   logic                   do_read, do_write, do_tick;
   logic [DATA_W-1:0]      cnt_mask;
   logic [DATA_W-1:0]      cnt_next;
   logic                   timer_zone;
   logic [TIMER_IDX_W-1:0] tidx;
   logic [4:0]             sub;
   logic [NUM_TIMERS-1:0]  tsel;
   logic [NUM_TIMERS-1:0]  hits, fsb_bits, msg_mask;
   logic [DATA_W-1:0]      rd_value;
   logic [DATA_W-1:0]      timer_word;

   hpet_cell_wr_type  cell_wr  [NUM_TIMERS];
   hpet_cell_sts_type cell_sts [NUM_TIMERS];
   logic [NUM_TIMERS-1:0][DATA_W-1:0] cfg_words, cmp_values, routes;

   // configuration port
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
         wide_ff   <= 1'b1;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_PERIOD: period_ff <= csr.data[PERIOD_W-1:0];
            CSR_WIDE:   wide_ff   <= csr.data[0];
            default: ;
         endcase
      end
   end

   // input register
   assign exec_go   = in_vld_ff && buf_free;
   assign req.ready = !in_vld_ff || buf_free;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req.ready) begin
         in_vld_in = req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_op_ff  <= hpet_op_type'(req.opcode);
         in_off_ff <= req.reg_offset;
         in_val_ff <= req.write_value;
      end
   end

   // decode
   assign do_read  = exec_go && (in_op_ff == OP_READ);
   assign do_write = exec_go && (in_op_ff == OP_WRITE);
   assign do_tick  = exec_go && (in_op_ff == OP_TICK) && gen_en_ff;

   assign cnt_mask   = wide_ff ? '1 : {{HALF_W{1'b0}}, {HALF_W{1'b1}}};
   assign cnt_next   = (cnt_ff + 1'b1) & cnt_mask;

   assign timer_zone = (in_off_ff[OFF_W-1:8] != '0);
   assign tidx       = in_off_ff[OFF_W-1:5] - TIMER_BLOCK_BASE;
   assign sub        = in_off_ff[4:0];

   always_comb begin
      for (int n = 0; n < NUM_TIMERS; n++) begin
         tsel[n] = timer_zone && (tidx == TIMER_IDX_W'(n));
      end
   end

   // comparator cells
   for (genvar n = 0; n < NUM_TIMERS; n++) begin : g_cell
      assign cell_wr[n].cfg_we   = do_write && tsel[n] && (sub == SUB_CFG);
      assign cell_wr[n].cmp_we   = do_write && tsel[n] && (sub == SUB_CMP);
      assign cell_wr[n].route_we = do_write && tsel[n] && (sub == SUB_ROUTE);

      hpet_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .wide      (wide_ff),
         .wr        (cell_wr[n]),
         .wdata     (in_val_ff),
         .cnt_next  (cnt_next),
         .sts       (cell_sts[n]),
         .cfg_word  (cfg_words[n]),
         .cmp_value (cmp_values[n]),
         .route     (routes[n])
      );

      assign hits[n]     = cell_sts[n].hit;
      assign fsb_bits[n] = cell_sts[n].fsb;
   end

   assign msg_mask = do_tick ? (hits & fsb_bits) : '0;

   // global state
   always_comb begin
      gen_en_in = gen_en_ff;
      cnt_in    = cnt_ff;
      sts_in    = sts_ff;
      if (do_write) begin
         unique case (in_off_ff)
            OFF_GCFG: gen_en_in = in_val_ff[0];
            OFF_STS:  sts_in    = sts_ff & ~in_val_ff[NUM_TIMERS-1:0];
            OFF_CNT:  cnt_in    = in_val_ff & cnt_mask;
            default: ;
         endcase
      end
      if (do_tick) begin
         cnt_in = cnt_next;
         sts_in = sts_ff | (hits & ~fsb_bits);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_en_ff <= 1'b0;
         cnt_ff    <= '0;
         sts_ff    <= '0;
      end else begin
         gen_en_ff <= gen_en_in;
         cnt_ff    <= cnt_in;
         sts_ff    <= sts_in;
      end
   end

   // read mux
   always_comb begin
      timer_word = '0;
      for (int n = 0; n < NUM_TIMERS; n++) begin
         if (tsel[n]) begin
            case (sub)
               SUB_CFG:   timer_word = timer_word | cfg_words[n];
               SUB_CMP:   timer_word = timer_word | cmp_values[n];
               SUB_ROUTE: timer_word = timer_word | routes[n];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      unique case (in_off_ff)
         OFF_CAP: begin
            rd_value = '0;
            rd_value[DATA_W-1:HALF_W] = HALF_W'(period_ff);
            rd_value[CAP_WIDE_BIT]    = wide_ff;
            rd_value[12:8]            = TIMER_IDX_W'(NUM_TIMERS - 1);
            rd_value[7:0]             = CAP_REVISION;
         end
         OFF_GCFG: rd_value = DATA_W'(gen_en_ff);
         OFF_STS:  rd_value = DATA_W'(sts_ff);
         OFF_CNT:  rd_value = cnt_ff & cnt_mask;
         default:  rd_value = timer_word;
      endcase
   end

   hpet_out_buf #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (exec_go),
      .load_read  (do_read),
      .load_value (rd_value),
      .load_mask  (msg_mask),
      .routes     (routes),
      .free       (buf_free),
      .rsp        (rsp)
   );

endmodule
